// File: hw/rtl/shadow_return_stack_checker_top_assert.svh
// ----------------------------------------------------------------------------
// Shadow return stack checker assertion macros
// Concurrent assertion helpers that sample on clk and are held off in reset.
// ----------------------------------------------------------------------------
`ifndef SHADOW_RETURN_STACK_CHECKER_TOP_ASSERT_SVH
`define SHADOW_RETURN_STACK_CHECKER_TOP_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define SRSC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that implies another one in the same cycle.
`define SRSC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another one in the next cycle.
`define SRSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/srsc_pkg.sv
// ----------------------------------------------------------------------------
// Shadow return stack checker package
// Sizes, codes and item types shared by the checker modules.
// ----------------------------------------------------------------------------
package srsc_pkg;

    localparam int STACK_ENTRIES = 1024;
    localparam int TABLE_ENTRIES = 16;
    localparam int ADDR_BITS     = 64;

    localparam int DEPTH_W     = $clog2(STACK_ENTRIES + 1);
    localparam int SADDR_W     = $clog2(STACK_ENTRIES);
    localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CTX_W       = 64;
    localparam int DEPTH_OUT_W = 11;

    localparam logic [1:0] KIND_ENTRY   = 2'd0;
    localparam logic [1:0] KIND_EXIT    = 2'd1;
    localparam logic [1:0] KIND_SETJMP  = 2'd2;
    localparam logic [1:0] KIND_LONGJMP = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_OVERFLOW   = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_MISMATCH   = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;
    localparam logic [2:0] ST_UNKNOWN    = 3'd5;
    localparam logic [2:0] ST_CONTEXT    = 3'd6;
    localparam logic [2:0] ST_RETURNED   = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] address;
        logic [63:0] context_req;
    } cmd_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [DEPTH_OUT_W-1:0] depth;
    } result_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } tbl_lookup_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    slot;
        logic [ADDR_BITS-1:0] key;
        logic [CTX_W-1:0]     ctx;
        logic [DEPTH_W-1:0]   mark;
    } tbl_wr_t;

endpackage

// File: hw/rtl/srsc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/srsc_buffer_table.sv
// ----------------------------------------------------------------------------
// Jump buffer table
// Keys are matched in parallel; context and depth mark live in a RAM.
// ----------------------------------------------------------------------------
module srsc_buffer_table
    import srsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 lookup_en,
    input  logic [ADDR_BITS-1:0] lookup_key,
    input  logic [CNT_W-1:0]     count,
    input  tbl_wr_t              wr,
    output tbl_lookup_t          lookup,
    output logic [CTX_W-1:0]     rd_ctx,
    output logic [DEPTH_W-1:0]   rd_mark
);

    logic [ADDR_BITS-1:0]     keys_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] match;
    logic                     hit;
    logic [SLOT_W-1:0]        slot;
    tbl_lookup_t              lookup_reg;
    tbl_lookup_t              lookup_next;
    logic [CTX_W+DEPTH_W-1:0] rdata;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match[i] = (CNT_W'(i) < count) && (keys_reg[i] == lookup_key);
        end
    end

    // The lowest matching slot wins.
    always_comb
    begin
        hit  = |match;
        slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                slot = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            keys_reg[wr.slot] <= wr.key;
        end
    end

    always_comb
    begin
        lookup_next = lookup_reg;
        if (lookup_en)
        begin
            lookup_next.hit  = hit;
            lookup_next.slot = slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookup_reg <= '0;
        end
        else
        begin
            lookup_reg <= lookup_next;
        end
    end

    srsc_ram #(
        .WIDTH(CTX_W + DEPTH_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ctx_ram (
        .clk  (clk),
        .we   (wr.en),
        .waddr(wr.slot),
        .wdata({wr.ctx, wr.mark}),
        .re   (lookup_en),
        .raddr(slot),
        .rdata(rdata)
    );

    assign lookup  = lookup_reg;
    assign rd_ctx  = rdata[CTX_W+DEPTH_W-1:DEPTH_W];
    assign rd_mark = rdata[DEPTH_W-1:0];

endmodule

// File: hw/rtl/shadow_return_stack_checker_top.sv
// ----------------------------------------------------------------------------
// Shadow return stack checker
// Return address shadow stack with setjmp and longjmp tracking.
// ----------------------------------------------------------------------------
// When an item is accepted the stack RAM is read at the top entry and the
// buffer table is searched and its RAM read; in the check state that follows,
// the read data is checked, the memories are written back and the result is
// loaded into the output register. The memories give registered read data,
// so the check waits for that state. A waiting result holds the block in its
// check cycle until it is taken. No clearing pass runs after reset.
module shadow_return_stack_checker_top
    import srsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    cmd_t                 item_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DEPTH_W-1:0]   depth_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    result_t              result_reg;
    result_t              result_next;
    logic                 accept;
    logic                 exec_go;
    logic [2:0]           status;
    logic                 stack_we;
    logic [ADDR_BITS-1:0] stack_rdata;
    logic [ADDR_BITS-1:0] item_addr;
    tbl_lookup_t          lookup;
    tbl_wr_t              tbl_wr;
    logic [CTX_W-1:0]     tbl_ctx;
    logic [DEPTH_W-1:0]   tbl_mark;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign exec_go   = (state_reg == S_EXEC) && (!result_valid_reg || result_ready);
    assign item_addr = item_reg.address[ADDR_BITS-1:0];

    srsc_ram #(
        .WIDTH(ADDR_BITS),
        .DEPTH(STACK_ENTRIES)
    ) u_stack_ram (
        .clk  (clk),
        .we   (stack_we),
        .waddr(SADDR_W'(depth_reg)),
        .wdata(item_addr),
        .re   (accept),
        .raddr(SADDR_W'(depth_reg - DEPTH_W'(1))),
        .rdata(stack_rdata)
    );

    srsc_buffer_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup_en (accept),
        .lookup_key(cmd.address[ADDR_BITS-1:0]),
        .count     (count_reg),
        .wr        (tbl_wr),
        .lookup    (lookup),
        .rd_ctx    (tbl_ctx),
        .rd_mark   (tbl_mark)
    );

    always_comb
    begin
        depth_next  = depth_reg;
        count_next  = count_reg;
        status      = ST_OK;
        stack_we    = 1'b0;
        tbl_wr.en   = 1'b0;
        tbl_wr.slot = lookup.slot;
        tbl_wr.key  = item_addr;
        tbl_wr.ctx  = item_reg.context_req;
        tbl_wr.mark = depth_reg;
        unique case (item_reg.kind)
            KIND_ENTRY:
            begin
                if (depth_reg >= DEPTH_W'(STACK_ENTRIES))
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    stack_we   = exec_go;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end
            KIND_EXIT:
            begin
                if (depth_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    depth_next = depth_reg - DEPTH_W'(1);
                    if (stack_rdata != item_addr)
                    begin
                        status = ST_MISMATCH;
                    end
                end
            end
            KIND_SETJMP:
            begin
                if (lookup.hit)
                begin
                    tbl_wr.en = exec_go;
                end
                else if (count_reg >= CNT_W'(TABLE_ENTRIES))
                begin
                    status = ST_TABLE_FULL;
                end
                else
                begin
                    tbl_wr.en   = exec_go;
                    tbl_wr.slot = SLOT_W'(count_reg);
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            KIND_LONGJMP:
            begin
                if (!lookup.hit)
                begin
                    status = ST_UNKNOWN;
                end
                else if (tbl_ctx != item_reg.context_req)
                begin
                    status = ST_CONTEXT;
                end
                else if (tbl_mark > depth_reg)
                begin
                    status = ST_RETURNED;
                end
                else
                begin
                    depth_next = tbl_mark;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next         = S_IDLE;
                    result_valid_next  = 1'b1;
                    result_next.status = status;
                    result_next.depth  = DEPTH_OUT_W'(depth_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            depth_reg        <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (exec_go)
            begin
                depth_reg <= depth_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            item_reg <= cmd;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "shadow_return_stack_checker_top_assert.svh"

    `SRSC_ASSERT_ALWAYS(a_depth_bound, depth_reg <= DEPTH_W'(STACK_ENTRIES), "stack depth above capacity")
    `SRSC_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(TABLE_ENTRIES), "buffer count above capacity")
    `SRSC_ASSERT_IMPLIES(a_overflow_full, result_valid_reg && result_reg.status == ST_OVERFLOW, result_reg.depth == DEPTH_OUT_W'(STACK_ENTRIES), "overflow reported below full depth")
    `SRSC_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC && !cmd_ready, "accepted item did not enter check cycle")

endmodule

// File: verif/srsc_result_monitor.sv
// ----------------------------------------------------------------------------
// Shadow return stack checker result monitor
// Watches both item channels of the block. Every accepted call event is run
// through a local copy of the shadow stack and the jump buffer table, and the
// status and depth so obtained are queued and compared with the results that
// the block hands out, in order. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module srsc_result_monitor
    import srsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  logic    cmd_ready,
    input  cmd_t    cmd,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    output int      fail_count,
    output int      results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ADDR_BITS-1:0] shadow_stack [STACK_ENTRIES];
    logic [DEPTH_W-1:0]   shadow_depth;
    logic [ADDR_BITS-1:0] jmp_keys     [TABLE_ENTRIES];
    logic [CTX_W-1:0]     jmp_contexts [TABLE_ENTRIES];
    logic [DEPTH_W-1:0]   jmp_marks    [TABLE_ENTRIES];
    logic [CNT_W-1:0]     jmp_count;
    result_t              expected_results [$];

    function automatic result_t predict_call_event(input cmd_t c);
        logic [ADDR_BITS-1:0] addr;
        logic [2:0]           status;
        int                   slot;
        result_t              r;
        addr   = c.address[ADDR_BITS-1:0];
        status = ST_OK;
        slot   = TABLE_ENTRIES;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (slot == TABLE_ENTRIES && i < jmp_count && jmp_keys[i] == addr)
                slot = i;
        end
        case (c.kind)
            KIND_ENTRY:
            begin
                if (shadow_depth >= STACK_ENTRIES)
                    status = ST_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_depth[SADDR_W-1:0]] = addr;
                    shadow_depth = shadow_depth + 1'b1;
                end
            end
            KIND_EXIT:
            begin
                if (shadow_depth == 0)
                    status = ST_EMPTY;
                else
                begin
                    shadow_depth = shadow_depth - 1'b1;
                    if (shadow_stack[shadow_depth[SADDR_W-1:0]] != addr)
                        status = ST_MISMATCH;
                end
            end
            KIND_SETJMP:
            begin
                if (slot == TABLE_ENTRIES)
                begin
                    if (jmp_count >= TABLE_ENTRIES)
                        status = ST_TABLE_FULL;
                    else
                    begin
                        slot = jmp_count;
                        jmp_count = jmp_count + 1'b1;
                    end
                end
                if (status == ST_OK)
                begin
                    jmp_keys[slot]     = addr;
                    jmp_contexts[slot] = c.context_req;
                    jmp_marks[slot]    = shadow_depth;
                end
            end
            default:
            begin
                if (slot == TABLE_ENTRIES)
                    status = ST_UNKNOWN;
                else if (jmp_contexts[slot] != c.context_req)
                    status = ST_CONTEXT;
                else if (jmp_marks[slot] > shadow_depth)
                    status = ST_RETURNED;
                else
                    shadow_depth = jmp_marks[slot];
            end
        endcase
        r.status = status;
        r.depth  = DEPTH_OUT_W'(shadow_depth);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            shadow_depth = '0;
            jmp_count    = '0;
            expected_results.delete();
            fail_count   = 0;
            results_owed = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: status %0d depth %0d",
                                 result.status, result.depth);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status || result.depth !== want.depth)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected status %0d depth %0d, %s",
                                     want.status, want.depth,
                                     $sformatf("got status %0d depth %0d",
                                               result.status, result.depth));
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                expected_results.push_back(predict_call_event(cmd));
            results_owed = expected_results.size();
        end
    end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Shadow return stack checker testbench
// Drives call events into the block: a short directed run through every
// status but overflow and table full, then random call and return sequences
// with jump buffers drawn from a small key pool, a fill of the whole stack,
// and a long output stall. Both channels idle at random in changing
// proportions. The monitor beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import srsc_pkg::*;

    localparam int POOL_KEYS   = 24;
    localparam int PHASE_ITEMS = 200;
    localparam int TAIL_ITEMS  = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_NS    = 3_000_000;

    logic    clk;
    logic    rst_n;
    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      fail_count;
    int      results_owed;

    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_request  = 1'b0;

    logic [63:0] call_trail [$];
    logic [63:0] key_pool   [POOL_KEYS];
    logic [63:0] pool_ctx   [POOL_KEYS];
    int          pool_mark  [POOL_KEYS];
    bit          pool_live  [POOL_KEYS];
    int          table_used;

    shadow_return_stack_checker_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    srsc_result_monitor monitor
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #LIMIT_NS;
        $display("testbench failed");
        $finish;
    end

    function automatic void track_call_event(input cmd_t c);
        int k;
        k = -1;
        for (int i = 0; i < POOL_KEYS; i++)
        begin
            if (key_pool[i] == c.address)
                k = i;
        end
        case (c.kind)
            KIND_ENTRY:
            begin
                if (call_trail.size() < STACK_ENTRIES)
                    call_trail.push_back(c.address);
            end
            KIND_EXIT:
            begin
                if (call_trail.size() > 0)
                    void'(call_trail.pop_back());
            end
            KIND_SETJMP:
            begin
                if (k < 0 || !pool_live[k])
                begin
                    if (table_used < TABLE_ENTRIES)
                    begin
                        table_used++;
                        if (k >= 0)
                            pool_live[k] = 1'b1;
                    end
                end
                if (k >= 0 && pool_live[k])
                begin
                    pool_ctx[k]  = c.context_req;
                    pool_mark[k] = call_trail.size();
                end
            end
            default:
            begin
                if (k >= 0 && pool_live[k] && pool_ctx[k] == c.context_req &&
                    pool_mark[k] <= call_trail.size())
                begin
                    while (call_trail.size() > pool_mark[k])
                        void'(call_trail.pop_back());
                end
            end
        endcase
    endfunction

    function automatic cmd_t pick_call_event();
        int   r;
        int   k;
        cmd_t c;
        r = $urandom_range(99);
        k = $urandom_range(POOL_KEYS - 1);
        c.kind        = KIND_ENTRY;
        c.address     = {$urandom, $urandom};
        c.context_req = {$urandom, $urandom};
        if (r < 5)
            c.kind = 2'($urandom_range(3));
        else if (r < 40)
            c.kind = KIND_ENTRY;
        else if (r < 70)
        begin
            c.kind = KIND_EXIT;
            if (call_trail.size() > 0 && $urandom_range(9) != 0)
                c.address = call_trail[$];
        end
        else if (r < 85)
        begin
            c.kind    = KIND_SETJMP;
            c.address = key_pool[k];
        end
        else
        begin
            c.kind    = KIND_LONGJMP;
            c.address = key_pool[k];
            if (pool_live[k] && $urandom_range(4) != 0)
                c.context_req = pool_ctx[k];
        end
        return c;
    endfunction

    task automatic send_call_event(input cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        track_call_event(c);
    endtask

    initial
    begin : receiver
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [63:0] fill_ctx;
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        table_used = 0;
        key_pool[0] = ~64'd0;
        key_pool[1] = 64'd0;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < POOL_KEYS; i++)
        begin
            pool_live[i] = 1'b0;
            pool_ctx[i]  = '0;
            pool_mark[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 58;
        send_call_event(cmd_t'{KIND_EXIT, ~64'd0, 64'd0});
        send_call_event(cmd_t'{KIND_LONGJMP, key_pool[0], 64'd0});
        send_call_event(cmd_t'{KIND_ENTRY, ~64'd0, ~64'd0});
        send_call_event(cmd_t'{KIND_ENTRY, 64'd0, 64'd0});
        send_call_event(cmd_t'{KIND_SETJMP, key_pool[0], ~64'd0});
        send_call_event(cmd_t'{KIND_ENTRY, 64'h0123_4567_89AB_CDEF, 64'd0});
        send_call_event(cmd_t'{KIND_SETJMP, key_pool[0], 64'd0});
        send_call_event(cmd_t'{KIND_LONGJMP, key_pool[0], ~64'd0});
        send_call_event(cmd_t'{KIND_LONGJMP, key_pool[0], 64'd0});
        send_call_event(cmd_t'{KIND_EXIT, 64'h0123_4567_89AB_CDEE, 64'd0});
        send_call_event(cmd_t'{KIND_LONGJMP, key_pool[0], 64'd0});
        send_call_event(cmd_t'{KIND_EXIT, 64'd0, ~64'd0});
        send_call_event(cmd_t'{KIND_EXIT, ~64'd0, 64'd0});
        send_call_event(cmd_t'{KIND_SETJMP, key_pool[1], ~64'd0});
        repeat (3) send_call_event(cmd_t'{KIND_ENTRY, {$urandom, $urandom}, 64'd0});
        send_call_event(cmd_t'{KIND_LONGJMP, key_pool[1], ~64'd0});
        send_call_event(cmd_t'{KIND_EXIT, {$urandom, $urandom}, 64'd0});

        repeat (PHASE_ITEMS) send_call_event(pick_call_event());

        send_idle_pct = 58;
        recv_idle_pct = 7;
        repeat (PHASE_ITEMS) send_call_event(pick_call_event());

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (40) send_call_event(pick_call_event());

        fill_ctx = {$urandom, $urandom};
        send_call_event(cmd_t'{KIND_SETJMP, key_pool[0], fill_ctx});
        while (call_trail.size() < STACK_ENTRIES)
            send_call_event(cmd_t'{KIND_ENTRY, {$urandom, $urandom}, 64'd0});
        repeat (2) send_call_event(cmd_t'{KIND_ENTRY, {$urandom, $urandom}, 64'd0});
        send_call_event(cmd_t'{KIND_EXIT, call_trail[$], 64'd0});
        send_call_event(cmd_t'{KIND_ENTRY, {$urandom, $urandom}, 64'd0});
        send_call_event(cmd_t'{KIND_LONGJMP, key_pool[0], fill_ctx});

        repeat (TAIL_ITEMS) send_call_event(pick_call_event());
        cmd_valid <= 1'b0;

        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
